/* rtl/core/hmf_pkg.sv */
`default_nettype none
package hmf_pkg;

	localparam int REPORT_BYTES = 64;
	localparam int POS_W        = $clog2(REPORT_BYTES);

	localparam logic [12:0] MAX_MSG_LEN  = 13'd7609;
	localparam logic [7:0]  CMD_FLAG     = 8'h80;
	localparam logic [31:0] CHANNEL_RST  = 32'hffff_ffff;

	typedef struct packed {
		logic [6:0]  hid_cmd;
		logic [12:0] msg_len;
		logic [7:0]  data_byte;
		logic        has_byte;
		logic        header_only;
		logic        first;
		logic        last;
	} item_t;

	typedef struct packed {
		logic [7:0] report_byte;
		logic       report_end;
		logic       run_end;
		logic       size_error;
	} result_t;

	// input stage status towards the framer
	typedef struct packed {
		logic valid;
		logic fresh;
	} stage_t;

	// framer control back to the input stage
	typedef struct packed {
		logic adv;
		logic release_item;
	} ctl_t;

endpackage
`default_nettype wire

/* rtl/core/hmf_in_stage.sv */
`default_nettype none
module hmf_in_stage (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          item_valid,
	output logic               item_stall,
	input  wire hmf_pkg::item_t item_in,
	input  wire hmf_pkg::ctl_t ctl,
	output hmf_pkg::stage_t    stage,
	output hmf_pkg::item_t     item_s1
);

	logic valid_s1;
	logic fresh_s1;
	logic accept;

	assign item_stall = valid_s1 && !ctl.release_item;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fresh_s1 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				fresh_s1 <= 1'b1;
			end else begin
				if (ctl.release_item)
					valid_s1 <= 1'b0;
				if (ctl.adv)
					fresh_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			item_s1 <= item_in;
	end

	assign stage.valid = valid_s1;
	assign stage.fresh = fresh_s1;

endmodule
`default_nettype wire

/* rtl/core/hmf_framer.sv */
`default_nettype none
module hmf_framer (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire hmf_pkg::stage_t stage,
	input  wire hmf_pkg::item_t  item_s1,
	input  wire logic [31:0]     channel_id,
	input  wire logic            out_ready,
	output hmf_pkg::ctl_t        ctl,
	output logic                 push,
	output hmf_pkg::result_t     res
);

	typedef enum logic [11:0] {
		K_NONE  = 12'b0000_0000_0001,
		K_CH0   = 12'b0000_0000_0010,
		K_CH1   = 12'b0000_0000_0100,
		K_CH2   = 12'b0000_0000_1000,
		K_CH3   = 12'b0000_0001_0000,
		K_CMD   = 12'b0000_0010_0000,
		K_LENHI = 12'b0000_0100_0000,
		K_LENLO = 12'b0000_1000_0000,
		K_SEQ   = 12'b0001_0000_0000,
		K_DATA  = 12'b0010_0000_0000,
		K_PAD   = 12'b0100_0000_0000,
		K_ERR   = 12'b1000_0000_0000
	} kind_t;

	kind_t                     kind_q;
	logic [hmf_pkg::POS_W-1:0] pos_q;
	logic [6:0]                seq_q;
	logic                      in_msg_q;
	logic                      drop_q;

	kind_t                     kind_init;
	kind_t                     kind_cur;
	kind_t                     kind_next;
	logic                      case_pad_only;
	logic                      restart;
	logic                      oversize;
	logic [hmf_pkg::POS_W-1:0] pos_eff;
	logic [hmf_pkg::POS_W:0]   pos_inc;
	logic                      wrap;
	logic [hmf_pkg::POS_W-1:0] pos_after;
	logic                      pad_more;
	logic                      emits;
	logic                      adv;
	logic                      done;
	logic                      counts;
	logic [7:0]                byte_val;

	always_comb begin
		case_pad_only = item_s1.first && in_msg_q && (pos_q != '0);
		restart       = stage.fresh && item_s1.first && !case_pad_only;
		oversize      = item_s1.msg_len > hmf_pkg::MAX_MSG_LEN;
		pos_eff       = restart ? '0 : pos_q;

		// first emission of a fresh request
		if (item_s1.first) begin
			if (case_pad_only)
				kind_init = K_PAD;
			else if (item_s1.header_only)
				kind_init = K_CH0;
			else if (oversize)
				kind_init = K_ERR;
			else
				kind_init = K_CH0;
		end else if (drop_q) begin
			kind_init = K_NONE;
		end else if (in_msg_q) begin
			if (item_s1.has_byte)
				kind_init = (pos_q == '0) ? K_CH0 : K_DATA;
			else if (item_s1.last && (pos_q != '0))
				kind_init = K_PAD;
			else
				kind_init = K_NONE;
		end else begin
			kind_init = K_NONE;
		end

		kind_cur = stage.fresh ? kind_init : kind_q;
		emits    = (kind_cur != K_NONE);
		counts   = emits && (kind_cur != K_ERR);

		pos_inc = {1'b0, pos_eff} + 1'b1;
		wrap    = counts && (pos_inc == (hmf_pkg::POS_W+1)'(hmf_pkg::REPORT_BYTES));
		if (!counts)
			pos_after = pos_eff;
		else if (wrap)
			pos_after = '0;
		else
			pos_after = pos_inc[hmf_pkg::POS_W-1:0];
		pad_more = (pos_after != '0);

		byte_val  = 8'h00;
		kind_next = K_NONE;
		unique case (kind_cur)
			K_NONE: begin
				kind_next = K_NONE;
			end
			K_CH0: begin
				byte_val  = channel_id[7:0];
				kind_next = K_CH1;
			end
			K_CH1: begin
				byte_val  = channel_id[15:8];
				kind_next = K_CH2;
			end
			K_CH2: begin
				byte_val  = channel_id[23:16];
				kind_next = K_CH3;
			end
			K_CH3: begin
				byte_val  = channel_id[31:24];
				kind_next = item_s1.first ? K_CMD : K_SEQ;
			end
			K_CMD: begin
				byte_val = hmf_pkg::CMD_FLAG | {1'b0, item_s1.hid_cmd};
				if (item_s1.header_only)
					kind_next = pad_more ? K_PAD : K_NONE;
				else
					kind_next = K_LENHI;
			end
			K_LENHI: begin
				byte_val  = {3'b000, item_s1.msg_len[12:8]};
				kind_next = K_LENLO;
			end
			K_LENLO: begin
				byte_val = item_s1.msg_len[7:0];
				if (item_s1.has_byte)
					kind_next = K_DATA;
				else if (item_s1.last && pad_more)
					kind_next = K_PAD;
				else
					kind_next = K_NONE;
			end
			K_SEQ: begin
				byte_val  = {1'b0, seq_q};
				kind_next = K_DATA;
			end
			K_DATA: begin
				byte_val  = item_s1.data_byte;
				kind_next = (item_s1.last && pad_more) ? K_PAD : K_NONE;
			end
			K_PAD: begin
				kind_next = pad_more ? K_PAD : K_NONE;
			end
			K_ERR: begin
				kind_next = K_NONE;
			end
			default: begin
				kind_next = K_NONE;
			end
		endcase

		adv  = stage.valid && (!emits || out_ready);
		done = (kind_next == K_NONE);
		push = adv && emits;

		res.report_byte = byte_val;
		res.report_end  = wrap;
		res.run_end     = done;
		res.size_error  = (kind_cur == K_ERR);

		ctl.adv          = adv;
		ctl.release_item = adv && done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= K_NONE;
			pos_q    <= '0;
			seq_q    <= '0;
			in_msg_q <= 1'b0;
			drop_q   <= 1'b0;
		end else if (adv) begin
			kind_q <= kind_next;
			pos_q  <= pos_after;
			if (restart)
				seq_q <= '0;
			else if (kind_cur == K_SEQ)
				seq_q <= seq_q + 7'd1;

			// message state settles when the request starts
			if (stage.fresh) begin
				if (item_s1.first) begin
					if (case_pad_only) begin
						in_msg_q <= 1'b0;
					end else begin
						drop_q   <= !item_s1.header_only && oversize && !item_s1.last;
						in_msg_q <= !item_s1.header_only && !oversize && !item_s1.last;
					end
				end else if (drop_q) begin
					if (item_s1.last)
						drop_q <= 1'b0;
				end else if (in_msg_q && item_s1.last) begin
					in_msg_q <= 1'b0;
				end
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/core/hmf_out_stage.sv */
`default_nettype none
module hmf_out_stage (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire hmf_pkg::result_t res,
	output logic                  out_ready,
	output logic                  res_valid,
	input  wire logic             res_stall,
	output hmf_pkg::result_t      res_q
);

	logic valid_q;

	assign out_ready = !valid_q || !res_stall;
	assign res_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (!res_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			res_q <= res;
	end

endmodule
`default_nettype wire

/* rtl/core/hid_message_framer_core.sv */
// path: the first report byte of a request goes from the input stage register to the result
//   register, and can wait between them while the result side stalls
// throughput: one report byte per cycle while the result side does not stall; a request
//   holds the input stage until its last byte moves on, or until the framer steps past it
//   when it gives none; the next request is taken on the edge that moves its last byte on
// reset: asynchronous, clears framing state and message flags; channel id returns to all ones
`default_nettype none
module hid_message_framer_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic [6:0]  hid_cmd,
	input  wire logic [12:0] msg_len,
	input  wire logic [7:0]  data_byte,
	input  wire logic        has_byte,
	input  wire logic        header_only,
	input  wire logic        first,
	input  wire logic        last,
	output logic             res_valid,
	input  wire logic        res_stall,
	output logic [7:0]       report_byte,
	output logic             report_end,
	output logic             run_end,
	output logic             size_error
);

	logic [31:0]      channel_id_q;
	hmf_pkg::item_t   item_in;
	hmf_pkg::item_t   item_s1;
	hmf_pkg::stage_t  stage;
	hmf_pkg::ctl_t    ctl;
	hmf_pkg::result_t res;
	hmf_pkg::result_t res_q;
	logic             push;
	logic             out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_id_q <= hmf_pkg::CHANNEL_RST;
		end else if (cfg_we) begin
			channel_id_q <= cfg_wdata;
		end
	end

	assign item_in.hid_cmd     = hid_cmd;
	assign item_in.msg_len     = msg_len;
	assign item_in.data_byte   = data_byte;
	assign item_in.has_byte    = has_byte;
	assign item_in.header_only = header_only;
	assign item_in.first       = first;
	assign item_in.last        = last;

	hmf_in_stage u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item_in    (item_in),
		.ctl        (ctl),
		.stage      (stage),
		.item_s1    (item_s1)
	);

	hmf_framer u_framer (
		.clk        (clk),
		.arst_n     (arst_n),
		.stage      (stage),
		.item_s1    (item_s1),
		.channel_id (channel_id_q),
		.out_ready  (out_ready),
		.ctl        (ctl),
		.push       (push),
		.res        (res)
	);

	hmf_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.res       (res),
		.out_ready (out_ready),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_q     (res_q)
	);

	assign report_byte = res_q.report_byte;
	assign report_end  = res_q.report_end;
	assign run_end     = res_q.run_end;
	assign size_error  = res_q.size_error;

endmodule
`default_nettype wire
